[hw/rtl/m4inv_pkg.sv]
// Shared types, constants and index functions of the 4x4 adjugate inverse.
package m4inv_pkg;

  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NUM_ELEMS      = 16;
  localparam int OUT_ELEM_W     = 32;
  localparam logic [2:0] LAST_TERM = 3'd5;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CF_RA,
    ST_CF_RB,
    ST_CF_RC,
    ST_CF_P,
    ST_CF_LO,
    ST_CF_HI,
    ST_CF_ACC,
    ST_DT_RD,
    ST_DT_LD,
    ST_DT_MUL,
    ST_DT_ACC,
    ST_DV_RD,
    ST_DV_LD,
    ST_DV_RUN,
    ST_DV_OUT
  } m4inv_state_t;

  typedef struct packed {
    logic done;
    logic clip;
  } m4inv_div_stat_t;

  // Address of factor j of Leibniz term t of the 3x3 minor that drops row r and column c.
  function automatic logic [3:0] minor_addr(input logic [1:0] r, input logic [1:0] c,
                                            input logic [2:0] t, input logic [1:0] j);
    logic [1:0] pj;
    logic [1:0] row;
    logic [1:0] col;
    unique case (t)
      3'd0: pj = j;
      3'd1: pj = (j == 2'd2) ? 2'd0 : j + 2'd1;
      3'd2: pj = (j == 2'd0) ? 2'd2 : j - 2'd1;
      3'd3: pj = (j == 2'd0) ? 2'd0 : ((j == 2'd1) ? 2'd2 : 2'd1);
      3'd4: pj = (j == 2'd0) ? 2'd1 : ((j == 2'd1) ? 2'd0 : 2'd2);
      default: pj = 2'd2 - j;
    endcase
    row = (j < r) ? j : j + 2'd1;
    col = (pj < c) ? pj : pj + 2'd1;
    return {row, col};
  endfunction

  // The last three permutations are odd.
  function automatic logic term_neg(input logic [2:0] t);
    return (t >= 3'd3);
  endfunction

endpackage

[hw/rtl/m4inv_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module m4inv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/m4inv_div.sv]
// Restoring divider with rounding and saturation for one inverse element.
module m4inv_div import m4inv_pkg::*; #(
  parameter int EW    = ELEM_WIDTH_DEF,
  parameter int DEN_W = 4 * ELEM_WIDTH_DEF + 3,
  parameter int NUM_W = 3 * ELEM_WIDTH_DEF + 2 + 2 * FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic            neg,
  output logic [EW-1:0]   val,
  output m4inv_div_stat_t stat
);

  localparam int DSH_W = DEN_W + EW + 1;
  localparam int DIV_W = (NUM_W > DSH_W) ? NUM_W : DSH_W;
  localparam int QW    = EW + 2;
  localparam int KW    = $clog2(EW + 2);

  logic             busy;
  logic             fin;
  logic             done;
  logic             clip;
  logic [KW-1:0]    k;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsh;
  logic [QW-1:0]    q;
  logic [DEN_W-1:0] dent;
  logic             negr;
  logic             ge;
  logic             rnd;
  logic [QW:0]      qr;
  logic [QW:0]      lim;
  logic             clipv;
  logic [QW:0]      mag;
  logic [QW:0]      sval;

  assign ge    = (rem >= dsh);
  assign rnd   = ({rem, 1'b0} >= {1'b0, DIV_W'(dent)});
  assign qr    = (QW + 1)'(q) + (QW + 1)'(rnd);
  assign lim   = ((QW + 1)'(1) << (EW - 1)) - (QW + 1)'(!negr);
  // The top quotient bit only sets when the quotient is far beyond range.
  assign clipv = q[QW-1] | (qr > lim);
  assign mag   = clipv ? lim : qr;
  assign sval  = negr ? -mag : mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        k    <= KW'(EW + 1);
      end else if (busy) begin
        k <= k - KW'(1);
        if (k == '0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= DIV_W'(num);
      dsh  <= DIV_W'(den) << (EW + 1);
      q    <= '0;
      dent <= den;
      negr <= neg;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      q   <= {q[QW-2:0], ge};
      dsh <= dsh >> 1;
    end else if (fin) begin
      val  <= sval[EW-1:0];
      clip <= clipv;
    end
  end

  assign stat.done = done;
  assign stat.clip = clip;

endmodule

[hw/rtl/matrix4_inverse_adjugate_core.sv]
// Top level: 4x4 matrix inverse by adjugate over a shared multiplier and two RAMs.
// Sequence: 16 elements are loaded, then 16 cofactors are built from 6 Leibniz terms each,
// then the determinant from the 4 row-0 element-cofactor products taken limb by limb, and
// each result of a non-singular matrix is then set by the bit-serial divider.
// Throughput is one matrix at a time; the next load starts once the last result is queued.
// Reset (rst, synchronous) clears the control state; the RAM contents stay undefined.
module matrix4_inverse_adjugate_core import m4inv_pkg::*; #(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] element
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] inverse_element, [35:32] position, [39:36] zero
  output logic [1:0]  m_tuser,   // [0] singular, [1] clipped
  output logic        m_tlast    // final_res
);

  localparam int EW    = ELEM_WIDTH;
  localparam int MW    = EW + 1;
  localparam int PW    = 2 * MW;
  localparam int COF_W = 3 * EW + 2;
  localparam int NL    = (COF_W + EW - 1) / EW;
  localparam int LW    = (NL > 1) ? $clog2(NL) : 1;
  localparam int CX_W  = NL * EW;
  localparam int DET_W = 4 * EW + 3;
  localparam int NUM_W = COF_W + 2 * FRAC_BITS;

  m4inv_state_t state;
  m4inv_state_t state_next;

  logic [3:0]              load_count;
  logic [3:0]              cidx;
  logic [2:0]              term;
  logic [LW-1:0]           limb;
  logic signed [EW-1:0]    ea;
  logic signed [EW-1:0]    ec;
  logic [2*EW-1:0]         p;
  logic signed [PW-1:0]    mres;
  logic [COF_W-1:0]        cofr;
  logic signed [DET_W-1:0] acc;
  logic [DET_W-1:0]        dabs;
  logic                    dneg;
  logic                    sing;

  logic [31:0] out_elem;
  logic [3:0]  out_pos;
  logic        out_sing;
  logic        out_clip;
  logic        out_last;

  logic [3:0]       mat_raddr;
  logic [EW-1:0]    mat_rdata;
  logic             mat_we;
  logic [3:0]       cof_raddr;
  logic [COF_W-1:0] cof_rdata;
  logic             cof_we;

  logic                    acc_en;
  logic                    acc_neg;
  logic [LW-1:0]           acc_limb;
  logic signed [DET_W-1:0] addend;
  logic signed [DET_W-1:0] acc_next;
  logic signed [MW-1:0]    mult_a;
  logic signed [MW-1:0]    mult_b;
  logic                    cf_neg;
  logic [CX_W-1:0]         cofx;
  logic [EW-1:0]           limb_bits;
  logic                    c_neg;
  logic [COF_W-1:0]        c_mag;
  logic                    div_start;
  logic                    out_load;
  logic [EW-1:0]           div_val;
  m4inv_div_stat_t         div_st;

  assign s_tready = (state == ST_LOAD);
  assign mat_we   = s_tvalid && s_tready;

  m4inv_ram #(.WIDTH(EW), .DEPTH(NUM_ELEMS)) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr (load_count),
    .wdata (s_tdata[EW-1:0]),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  // Cofactor writes and reads never overlap: the sequencer finishes all writes first.
  m4inv_ram #(.WIDTH(COF_W), .DEPTH(NUM_ELEMS)) u_cof_ram (
    .clk   (clk),
    .we    (cof_we),
    .waddr (cidx),
    .wdata (acc_next[COF_W-1:0]),
    .raddr (cof_raddr),
    .rdata (cof_rdata)
  );

  assign c_neg = cof_rdata[COF_W-1];
  assign c_mag = c_neg ? -cof_rdata : cof_rdata;

  m4inv_div #(.EW(EW), .DEN_W(DET_W), .NUM_W(NUM_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({c_mag, {(2 * FRAC_BITS){1'b0}}}),
    .den   (dabs),
    .neg   (c_neg ^ dneg),
    .val   (div_val),
    .stat  (div_st)
  );

  assign cf_neg    = term_neg(term) ^ cidx[2] ^ cidx[0];
  assign cofx      = CX_W'(signed'(cofr));
  assign limb_bits = cofx[int'(limb) * EW +: EW];
  assign addend    = DET_W'(mres) <<< (int'(acc_limb) * EW);
  assign acc_next  = acc + (acc_neg ? -addend : addend);

  always_comb begin
    state_next = state;
    mat_raddr  = '0;
    cof_raddr  = '0;
    cof_we     = 1'b0;
    acc_en     = 1'b0;
    acc_neg    = 1'b0;
    acc_limb   = '0;
    mult_a     = '0;
    mult_b     = '0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_LOAD: begin
        if (s_tvalid && (load_count == 4'(NUM_ELEMS - 1))) begin
          state_next = ST_CF_RA;
        end
      end
      ST_CF_RA: begin
        mat_raddr  = minor_addr(cidx[3:2], cidx[1:0], term, 2'd0);
        state_next = ST_CF_RB;
      end
      ST_CF_RB: begin
        mat_raddr  = minor_addr(cidx[3:2], cidx[1:0], term, 2'd1);
        state_next = ST_CF_RC;
      end
      ST_CF_RC: begin
        mat_raddr  = minor_addr(cidx[3:2], cidx[1:0], term, 2'd2);
        mult_a     = MW'(ea);
        mult_b     = MW'(signed'(mat_rdata));
        state_next = ST_CF_P;
      end
      ST_CF_P: begin
        state_next = ST_CF_LO;
      end
      ST_CF_LO: begin
        mult_a     = {1'b0, p[EW-1:0]};
        mult_b     = MW'(ec);
        state_next = ST_CF_HI;
      end
      ST_CF_HI: begin
        acc_en     = 1'b1;
        acc_neg    = cf_neg;
        mult_a     = MW'(signed'(p[2*EW-1:EW]));
        mult_b     = MW'(ec);
        state_next = ST_CF_ACC;
      end
      ST_CF_ACC: begin
        acc_en   = 1'b1;
        acc_neg  = cf_neg;
        acc_limb = LW'(1);
        if (term == LAST_TERM) begin
          cof_we     = 1'b1;
          state_next = (cidx == 4'(NUM_ELEMS - 1)) ? ST_DT_RD : ST_CF_RA;
        end else begin
          state_next = ST_CF_RA;
        end
      end
      ST_DT_RD: begin
        mat_raddr  = {2'b00, cidx[1:0]};
        cof_raddr  = {2'b00, cidx[1:0]};
        state_next = ST_DT_LD;
      end
      ST_DT_LD: begin
        state_next = ST_DT_MUL;
      end
      ST_DT_MUL: begin
        mult_a     = {(limb == LW'(NL - 1)) ? limb_bits[EW-1] : 1'b0, limb_bits};
        mult_b     = MW'(ea);
        state_next = ST_DT_ACC;
      end
      ST_DT_ACC: begin
        acc_en   = 1'b1;
        acc_limb = limb;
        if (limb == LW'(NL - 1)) begin
          state_next = (cidx[1:0] == 2'd3) ? ST_DV_RD : ST_DT_RD;
        end else begin
          state_next = ST_DT_MUL;
        end
      end
      ST_DV_RD: begin
        // Transposed cofactor: result (r,c) takes cofactor (c,r).
        cof_raddr  = {cidx[1:0], cidx[3:2]};
        state_next = ST_DV_LD;
      end
      ST_DV_LD: begin
        if (sing) begin
          state_next = ST_DV_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DV_RUN;
        end
      end
      ST_DV_RUN: begin
        if (div_st.done) begin
          state_next = ST_DV_OUT;
        end
      end
      ST_DV_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = (cidx == 4'(NUM_ELEMS - 1)) ? ST_LOAD : ST_DV_RD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      cidx       <= '0;
      term       <= '0;
      limb       <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (mat_we) begin
        load_count <= load_count + 4'd1;
      end
      if (state == ST_CF_ACC) begin
        if (term == LAST_TERM) begin
          term <= '0;
          cidx <= cidx + 4'd1;
        end else begin
          term <= term + 3'd1;
        end
      end
      if (state == ST_DT_LD) begin
        limb <= '0;
      end
      if (state == ST_DT_ACC) begin
        if (limb == LW'(NL - 1)) begin
          cidx <= (cidx[1:0] == 2'd3) ? 4'd0 : cidx + 4'd1;
        end else begin
          limb <= limb + LW'(1);
        end
      end
      if (out_load) begin
        cidx     <= cidx + 4'd1;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mres <= mult_a * mult_b;
    // The accumulator starts clean for each matrix and after each finished cofactor.
    if ((state == ST_LOAD) || ((state == ST_CF_ACC) && (term == LAST_TERM))) begin
      acc <= '0;
    end else if (acc_en) begin
      acc <= acc_next;
    end
    if (state == ST_CF_RB) begin
      ea <= mat_rdata;
    end
    if (state == ST_CF_P) begin
      p  <= mres[2*EW-1:0];
      ec <= mat_rdata;
    end
    if (state == ST_DT_LD) begin
      ea   <= mat_rdata;
      cofr <= cof_rdata;
    end
    if ((state == ST_DT_ACC) && (limb == LW'(NL - 1)) && (cidx[1:0] == 2'd3)) begin
      dneg <= acc_next[DET_W-1];
      dabs <= acc_next[DET_W-1] ? DET_W'(-acc_next) : DET_W'(acc_next);
      sing <= (acc_next == '0);
    end
    if (out_load) begin
      out_elem <= sing ? '0 : OUT_ELEM_W'(signed'(div_val));
      out_pos  <= cidx;
      out_sing <= sing;
      out_clip <= sing ? 1'b0 : div_st.clip;
      out_last <= (cidx == 4'(NUM_ELEMS - 1));
    end
  end

  assign m_tdata = {4'b0000, out_pos, out_elem};
  assign m_tuser = {out_clip, out_sing};
  assign m_tlast = out_last;

`ifndef SYNTHESIS
  a_div_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DV_LD && !sing) |-> (dabs != '0))
    else $error("divider started with a zero determinant");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == ST_DV_RUN))
    else $error("divider finished while the sequencer was not waiting");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[31:0] == 32'd0 && !m_tuser[1]))
    else $error("singular item carries a nonzero or clipped element");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_DV_OUT))
    else $error("output item raised outside the result step");
`endif

endmodule

[tb/matrix4_inverse_adjugate_core_test.sv]
// Self-checking testbench of the 4x4 adjugate matrix inverse core.
`timescale 1ns / 100ps

module matrix4_inverse_adjugate_core_test;
  import m4inv_pkg::*;

  typedef struct {
    logic [31:0] value;
    logic [3:0]  pos;
    logic        singular;
    logic        clipped;
    logic        last;
  } inv_item_t;

  typedef struct {
    logic [31:0] element;
    logic        typed;    // expected inverse typed in rather than predicted
  } stim_row_t;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int RANDOM_MATRICES = 19;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  inv_item_t   inverse_q[$];
  logic [31:0] mat[16];
  int          load_cnt = 0;
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          quiet_cycles = 0;
  stim_row_t   directed[32];

  always #6 clk = ~clk;

  matrix4_inverse_adjugate_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  function automatic logic signed [191:0] entry(int r, int c);
    return {{160{mat[r * 4 + c][31]}}, mat[r * 4 + c]};
  endfunction

  // Signed 3x3 minor, times (-1)^(r+c), exact.
  function automatic logic signed [191:0] signed_cofactor(int r, int c);
    int rs[3];
    int cs[3];
    int n;
    logic signed [191:0] m[3][3];
    logic signed [191:0] d;
    n = 0;
    for (int k = 0; k < 4; k++) if (k != r) begin rs[n] = k; n++; end
    n = 0;
    for (int k = 0; k < 4; k++) if (k != c) begin cs[n] = k; n++; end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) m[i][j] = entry(rs[i], cs[j]);
    d = m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
      - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
      + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
    return ((r + c) % 2 == 1) ? -d : d;
  endfunction

  function automatic void predict_inverse();
    logic signed [191:0] cof[16];
    logic signed [191:0] det;
    logic [191:0] num, den, quo, rem, lim;
    logic neg;
    inv_item_t it;
    det = '0;
    for (int i = 0; i < 16; i++) cof[i] = signed_cofactor(i / 4, i % 4);
    for (int i = 0; i < 4; i++) det = det + entry(0, i) * cof[i];
    for (int i = 0; i < 16; i++) begin
      it.pos = i[3:0];
      it.last = (i == 15);
      it.singular = (det == 0);
      it.clipped = 1'b0;
      it.value = '0;
      if (det != 0) begin
        neg = cof[(i % 4) * 4 + i / 4][191] != det[191];
        num = (cof[(i % 4) * 4 + i / 4][191] ? -cof[(i % 4) * 4 + i / 4]
                                              : cof[(i % 4) * 4 + i / 4]) << 32;
        den = det[191] ? -det : det;
        quo = num / den;
        rem = num % den;
        if ((rem << 1) >= den) quo = quo + 1;
        lim = neg ? 192'h8000_0000 : 192'h7FFF_FFFF;
        if (quo > lim) begin
          quo = lim;
          it.clipped = 1'b1;
        end
        it.value = neg ? -quo[31:0] : quo[31:0];
      end
      inverse_q.push_back(it);
    end
  endfunction

  task automatic send(input logic [31:0] x, input logic typed);
    inv_item_t it;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= x;
    do @(posedge clk); while (!s_tready);
    mat[load_cnt] = x;
    load_cnt++;
    if (load_cnt == 16) begin
      load_cnt = 0;
      if (typed) begin
        // An all-zero matrix is singular: zeros with the singular flag.
        for (int p = 0; p < 16; p++) begin
          it.value = '0;
          it.pos = p[3:0];
          it.singular = 1'b1;
          it.clipped = 1'b0;
          it.last = (p == 15);
          inverse_q.push_back(it);
        end
      end else begin
        predict_inverse();
      end
    end
  endtask

  function automatic logic [31:0] pick_element(int kind);
    case (kind)
      0: return $urandom();
      1: return $urandom_range(262144) - 131072;
      2: return $urandom_range(32) - 16;
      default: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0001_0000;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  // Each random matrix is one of: full range, moderate, tiny, extremes, or singular.
  task automatic send_random_matrix();
    logic [31:0] m[16];
    int kind;
    int src;
    kind = $urandom_range(5);
    for (int i = 0; i < 16; i++) m[i] = pick_element(kind == 5 ? 1 : kind);
    if (kind == 1)
      for (int d = 0; d < 4; d++) m[d * 5] = m[d * 5] + 32'h0004_0000;
    if (kind == 5) begin
      src = $urandom_range(3);
      case ($urandom_range(2))
        0: for (int c = 0; c < 4; c++) m[((src + 1) % 4) * 4 + c] = m[src * 4 + c];
        1: for (int r = 0; r < 4; r++) m[r * 4 + src] = '0;
        default: for (int i = 0; i < 16; i++) m[i] = '0;
      endcase
    end
    for (int i = 0; i < 16; i++) send(m[i], 1'b0);
  endtask

  task automatic set_phase(input int matrix_idx);
    if (matrix_idx < 7) begin
      send_idle_pct = 36;
      recv_idle_pct = 45;
    end else if (matrix_idx < 14) begin
      send_idle_pct = 45;
      recv_idle_pct = 36;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  always @(posedge clk) begin
    inv_item_t exp_it;
    if (!rst) begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("matrix4_inverse_adjugate_core_test failed");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        if (inverse_q.size() == 0) begin
          $error("unexpected result at position %0d", m_tdata[35:32]);
          errors++;
        end else begin
          exp_it = inverse_q.pop_front();
          if (m_tdata[31:0] !== exp_it.value) begin
            $error("inverse_element expected %h actual %h", exp_it.value, m_tdata[31:0]);
            errors++;
          end
          if (m_tdata[35:32] !== exp_it.pos) begin
            $error("position expected %0d actual %0d", exp_it.pos, m_tdata[35:32]);
            errors++;
          end
          if (m_tuser[0] !== exp_it.singular) begin
            $error("singular expected %b actual %b", exp_it.singular, m_tuser[0]);
            errors++;
          end
          if (m_tuser[1] !== exp_it.clipped) begin
            $error("clipped expected %b actual %b", exp_it.clipped, m_tuser[1]);
            errors++;
          end
          if (m_tlast !== exp_it.last) begin
            $error("final_res expected %b actual %b", exp_it.last, m_tlast);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    // Zero matrix first, then a diagonal of extremes: raw 1 clips, full scale does not.
    for (int i = 0; i < 16; i++) directed[i] = '{32'h0, 1'b1};
    for (int i = 16; i < 32; i++) directed[i] = '{32'h0, 1'b0};
    directed[16].element = 32'h0000_0001;
    directed[21].element = 32'h8000_0000;
    directed[26].element = 32'h7FFF_FFFF;
    directed[31].element = 32'hFFFF_0000;
    directed[17].element = 32'hFFFF_FFFF;
    directed[24].element = 32'h0001_0000;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    set_phase(0);
    foreach (directed[i]) send(directed[i].element, directed[i].typed);
    for (int k = 0; k < RANDOM_MATRICES; k++) begin
      set_phase(k + 2);
      if (k == 8) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (inverse_q.size() != 0);
      end
      send_random_matrix();
    end
    s_tvalid <= 1'b0;
    do @(posedge clk); while (inverse_q.size() != 0);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("matrix4_inverse_adjugate_core_test passed");
    else $display("matrix4_inverse_adjugate_core_test failed");
    $finish;
  end

endmodule

[matrix4_inverse_adjugate_core.f]
hw/rtl/m4inv_pkg.sv
hw/rtl/m4inv_ram.sv
hw/rtl/m4inv_div.sv
hw/rtl/matrix4_inverse_adjugate_core.sv
tb/matrix4_inverse_adjugate_core_test.sv
